>>> hdl/assert_macros.svh
// assertion macros used by the checker file tpc_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

>>> hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// types, constants and helpers for the temperature and pressure compensation
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int unsigned DivSteps = 32;

   localparam logic [31:0] PressOffset = 32'd64000;
   localparam logic [31:0] PressBase   = 32'd1048576;
   localparam logic [31:0] PressScale  = 32'd3125;
   localparam logic [31:0] DenBias     = 32'd32768;
   localparam logic [31:0] RoundTemp   = 32'd128;

   typedef enum logic [1:0] {
      CSR_CAL_TEMP    = 2'd0,
      CSR_CAL_PRESS_A = 2'd1,
      CSR_CAL_PRESS_B = 2'd2,
      CSR_CAL_P9      = 2'd3
   } csr_index_type;

   // calibration words, each widened to 32 bits
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } cal_type;

   // temperature results that ride along with the pressure work
   typedef struct packed {
      logic [31:0] tc;
      logic [31:0] fine;
   } side_type;

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
      asr = 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] full;
      full  = 64'(a) * 64'(b);
      mul32 = full[31:0];
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      sext16 = {{16{v[15]}}, v};
   endfunction

endpackage

>>> hdl/tpc_temp.sv
// ----------------------------------------------------------------------------
// tpc_temp
// five-stage temperature path: fine temperature, centidegrees, pressure seed
// ----------------------------------------------------------------------------
module tpc_temp
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [19:0] raw_temp,
   input  logic [19:0] raw_press,
   output logic        out_valid,
   output side_type    out_side,
   output logic [31:0] out_pv1,
   output logic [31:0] out_ap
);

   logic [4:0]  valid_ff, valid_in;
   logic [31:0] a_ff, a_in, d_ff, d_in;
   logic [31:0] m1_ff, m1_in, dd_ff, dd_in;
   logic [31:0] v1t_ff, v1t_in, m2_ff, m2_in;
   logic [31:0] fine4_ff, fine4_in;
   logic [31:0] tc_ff, tc_in, fine5_ff, fine5_in, pv1_ff, pv1_in;
   logic [31:0] ap_ff [0:4];
   logic [31:0] ap_in;
   logic [31:0] f5;

   assign valid_in = {valid_ff[3:0], in_valid};
   assign ap_in    = 32'(raw_press);

   always_comb begin
      a_in     = 32'(raw_temp >> 3) - (cal.t1 << 1);
      d_in     = 32'(raw_temp >> 4) - cal.t1;
      m1_in    = mul32(a_ff, cal.t2);
      dd_in    = mul32(d_ff, d_ff);
      v1t_in   = asr(m1_ff, 11);
      m2_in    = mul32(asr(dd_ff, 12), cal.t3);
      fine4_in = v1t_ff + asr(m2_ff, 14);
      f5       = fine4_ff + (fine4_ff << 2);
      tc_in    = asr(f5 + RoundTemp, 8);
      fine5_in = fine4_ff;
      pv1_in   = asr(fine4_ff, 1) - PressOffset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         d_ff     <= d_in;
         m1_ff    <= m1_in;
         dd_ff    <= dd_in;
         v1t_ff   <= v1t_in;
         m2_ff    <= m2_in;
         fine4_ff <= fine4_in;
         tc_ff    <= tc_in;
         fine5_ff <= fine5_in;
         pv1_ff   <= pv1_in;
         ap_ff[0] <= ap_in;
         for (int i = 1; i < 5; i++) begin
            ap_ff[i] <= ap_ff[i-1];
         end
      end
   end

   assign out_valid     = valid_ff[4];
   assign out_side.tc   = tc_ff;
   assign out_side.fine = fine5_ff;
   assign out_pv1       = pv1_ff;
   assign out_ap        = ap_ff[4];

endmodule

>>> hdl/tpc_press.sv
// ----------------------------------------------------------------------------
// tpc_press
// six-stage pressure path up to the dividend and divisor
// ----------------------------------------------------------------------------
module tpc_press
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  cal_type     cal,
   input  logic        in_valid,
   input  side_type    in_side,
   input  logic [31:0] in_pv1,
   input  logic [31:0] in_ap,
   output logic        out_valid,
   output side_type    out_side,
   output logic [31:0] out_dividend,
   output logic [31:0] out_den,
   output logic        out_mul2,
   output logic        out_dz
);

   localparam int Stages = 6;

   logic [Stages-1:0] valid_ff, valid_in;
   side_type    side_ff [0:Stages-1];
   logic [31:0] ap_ff [0:3];
   logic [31:0] sq_ff, sq_in, mp5_ff, mp5_in, mp2_ff, mp2_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, mp5b_ff, mp2b_ff;
   logic [31:0] v2_ff, v2_in, v1x_ff, v1x_in;
   logic [31:0] m_ff, m_in, v2b_ff, v2b_in;
   logic [31:0] den_ff, den_in, num_ff, num_in;
   logic [31:0] pn_ff, pn_in, den5_ff;
   logic [31:0] q;

   assign valid_in = {valid_ff[Stages-2:0], in_valid};

   always_comb begin
      q      = asr(in_pv1, 2);
      sq_in  = mul32(q, q);
      mp5_in = mul32(in_pv1, cal.p5);
      mp2_in = mul32(cal.p2, in_pv1);
      a_in   = mul32(asr(sq_ff, 11), cal.p6);
      b_in   = mul32(cal.p3, asr(sq_ff, 13));
      v2_in  = asr(a_ff + (mp5b_ff << 1), 2) + (cal.p4 << 16);
      v1x_in = asr(asr(b_ff, 3) + asr(mp2b_ff, 1), 18);
      m_in   = mul32(DenBias + v1x_ff, cal.p1);
      v2b_in = asr(v2_ff, 12);
      den_in = asr(m_ff, 15);
      num_in = PressBase - ap_ff[3] - v2b_ff;
      pn_in  = mul32(num_ff, PressScale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < Stages; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         ap_ff[0] <= in_ap;
         for (int i = 1; i < 4; i++) begin
            ap_ff[i] <= ap_ff[i-1];
         end
         sq_ff   <= sq_in;
         mp5_ff  <= mp5_in;
         mp2_ff  <= mp2_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         mp5b_ff <= mp5_ff;
         mp2b_ff <= mp2_ff;
         v2_ff   <= v2_in;
         v1x_ff  <= v1x_in;
         m_ff    <= m_in;
         v2b_ff  <= v2b_in;
         den_ff  <= den_in;
         num_ff  <= num_in;
         pn_ff   <= pn_in;
         den5_ff <= den_ff;
      end
   end

   assign out_valid    = valid_ff[Stages-1];
   assign out_side     = side_ff[Stages-1];
   assign out_mul2     = pn_ff[31];
   assign out_dividend = pn_ff[31] ? pn_ff : (pn_ff << 1);
   assign out_den      = den5_ff;
   assign out_dz       = (den5_ff == '0);

endmodule

>>> hdl/tpc_div.sv
// ----------------------------------------------------------------------------
// tpc_div
// pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tpc_div
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  side_type    in_side,
   input  logic [31:0] in_dividend,
   input  logic [31:0] in_den,
   input  logic        in_mul2,
   input  logic        in_dz,
   output logic        out_valid,
   output side_type    out_side,
   output logic [31:0] out_quo,
   output logic        out_mul2,
   output logic        out_dz
);

   logic [DivSteps-1:0] valid_ff, valid_in;
   logic [31:0] rem_ff [0:DivSteps-1];
   logic [31:0] quo_ff [0:DivSteps-1];
   logic [31:0] dvd_ff [0:DivSteps-1];
   logic [31:0] den_ff [0:DivSteps-1];
   side_type    side_ff [0:DivSteps-1];
   logic        mul2_ff [0:DivSteps-1];
   logic        dz_ff [0:DivSteps-1];
   logic [31:0] rem_in [0:DivSteps-1];
   logic [31:0] quo_in [0:DivSteps-1];
   logic [31:0] dvd_in [0:DivSteps-1];

   assign valid_in = {valid_ff[DivSteps-2:0], in_valid};

   always_comb begin
      logic [32:0] trial;
      logic [31:0] r, qv, dv, dn;
      for (int k = 0; k < DivSteps; k++) begin
         if (k == 0) begin
            r  = '0;
            qv = '0;
            dv = in_dividend;
            dn = in_den;
         end else begin
            r  = rem_ff[k-1];
            qv = quo_ff[k-1];
            dv = dvd_ff[k-1];
            dn = den_ff[k-1];
         end
         trial = {r, dv[31]};
         if (trial >= {1'b0, dn}) begin
            trial = trial - {1'b0, dn};
            quo_in[k] = {qv[30:0], 1'b1};
         end else begin
            quo_in[k] = {qv[30:0], 1'b0};
         end
         rem_in[k] = trial[31:0];
         dvd_in[k] = dv << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DivSteps; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            dvd_ff[k] <= dvd_in[k];
         end
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         mul2_ff[0] <= in_mul2;
         dz_ff[0]   <= in_dz;
         for (int k = 1; k < DivSteps; k++) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
            mul2_ff[k] <= mul2_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_side  = side_ff[DivSteps-1];
   assign out_quo   = quo_ff[DivSteps-1];
   assign out_mul2  = mul2_ff[DivSteps-1];
   assign out_dz    = dz_ff[DivSteps-1];

endmodule

>>> hdl/tpc_post.sv
// ----------------------------------------------------------------------------
// tpc_post
// four-stage pressure correction after the divide, ending in the result register
// ----------------------------------------------------------------------------
module tpc_post
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  cal_type     cal,
   input  logic        in_valid,
   input  side_type    in_side,
   input  logic [31:0] in_quo,
   input  logic        in_mul2,
   input  logic        in_dz,
   output logic        out_valid,
   output side_type    out_side,
   output logic [31:0] out_press,
   output logic        out_dz
);

   localparam int Stages = 4;

   logic [Stages-1:0] valid_ff, valid_in;
   side_type    side_ff [0:Stages-1];
   logic        dz_ff [0:Stages-1];
   logic [31:0] p_ff [0:2];
   logic [31:0] p_in, sqm_ff, sqm_in, m8_ff, m8_in;
   logic [31:0] mp9_ff, mp9_in, v2_ff, v2_in, res_ff, res_in;
   logic [31:0] s;

   assign valid_in = {valid_ff[Stages-2:0], in_valid};

   always_comb begin
      p_in   = in_mul2 ? (in_quo << 1) : in_quo;
      s      = p_ff[0] >> 3;
      sqm_in = mul32(s, s);
      m8_in  = mul32(p_ff[0] >> 2, cal.p8);
      mp9_in = mul32(cal.p9, sqm_ff >> 13);
      v2_in  = asr(m8_ff, 13);
      res_in = dz_ff[2] ? '0 : p_ff[2] + asr(asr(mp9_ff, 12) + v2_ff + cal.p7, 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         dz_ff[0]   <= in_dz;
         for (int i = 1; i < Stages; i++) begin
            side_ff[i] <= side_ff[i-1];
            dz_ff[i]   <= dz_ff[i-1];
         end
         p_ff[0] <= p_in;
         p_ff[1] <= p_ff[0];
         p_ff[2] <= p_ff[1];
         sqm_ff  <= sqm_in;
         m8_ff   <= m8_in;
         mp9_ff  <= mp9_in;
         v2_ff   <= v2_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];
   assign out_press = res_ff;
   assign out_dz    = dz_ff[Stages-1];

endmodule

>>> hdl/temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// temp_pressure_compensation
// 32-bit integer temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    raw_temp, raw_press
//  rsp      out        rsp_valid/stall    temp_centi, fine_temp, press_pa, div_zero
//  csr      in         csr_write          csr_index, csr_data
//
//  one transfer per cycle unless a stalled result freezes the pipeline
//  the 32-stage divider sets the depth, one quotient bit per stage
//  synchronous reset clears all valid bits and the calibration registers
//  a stalled result freezes the whole pipeline and req_stall follows it
// ----------------------------------------------------------------------------
module temp_pressure_compensation
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temp,
   input  logic [19:0] req_raw_press,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_temp_centi,
   output logic [31:0] rsp_fine_temp,
   output logic [31:0] rsp_press_pa,
   output logic        rsp_div_zero,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_p9_ff;
   cal_type     cal;
   logic        en;

   logic        t_valid;
   side_type    t_side;
   logic [31:0] t_pv1, t_ap;
   logic        p_valid, p_mul2, p_dz;
   side_type    p_side;
   logic [31:0] p_dividend, p_den;
   logic        d_valid, d_mul2, d_dz;
   side_type    d_side;
   logic [31:0] d_quo;
   side_type    o_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_p9_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_data[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_data;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_data;
            CSR_CAL_P9:      cal_p9_ff      <= csr_data[15:0];
            default:         cal_p9_ff      <= cal_p9_ff;
         endcase
      end
   end

   assign cal.t1 = 32'(cal_temp_ff[15:0]);
   assign cal.t2 = sext16(cal_temp_ff[31:16]);
   assign cal.t3 = sext16(cal_temp_ff[47:32]);
   assign cal.p1 = 32'(cal_press_a_ff[15:0]);
   assign cal.p2 = sext16(cal_press_a_ff[31:16]);
   assign cal.p3 = sext16(cal_press_a_ff[47:32]);
   assign cal.p4 = sext16(cal_press_a_ff[63:48]);
   assign cal.p5 = sext16(cal_press_b_ff[15:0]);
   assign cal.p6 = sext16(cal_press_b_ff[31:16]);
   assign cal.p7 = sext16(cal_press_b_ff[47:32]);
   assign cal.p8 = sext16(cal_press_b_ff[63:48]);
   assign cal.p9 = sext16(cal_p9_ff);

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   tpc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_valid  (req_valid),
      .raw_temp  (req_raw_temp),
      .raw_press (req_raw_press),
      .out_valid (t_valid),
      .out_side  (t_side),
      .out_pv1   (t_pv1),
      .out_ap    (t_ap)
   );

   tpc_press u_press (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cal          (cal),
      .in_valid     (t_valid),
      .in_side      (t_side),
      .in_pv1       (t_pv1),
      .in_ap        (t_ap),
      .out_valid    (p_valid),
      .out_side     (p_side),
      .out_dividend (p_dividend),
      .out_den      (p_den),
      .out_mul2     (p_mul2),
      .out_dz       (p_dz)
   );

   tpc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (p_valid),
      .in_side     (p_side),
      .in_dividend (p_dividend),
      .in_den      (p_den),
      .in_mul2     (p_mul2),
      .in_dz       (p_dz),
      .out_valid   (d_valid),
      .out_side    (d_side),
      .out_quo     (d_quo),
      .out_mul2    (d_mul2),
      .out_dz      (d_dz)
   );

   tpc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cal       (cal),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_quo    (d_quo),
      .in_mul2   (d_mul2),
      .in_dz     (d_dz),
      .out_valid (rsp_valid),
      .out_side  (o_side),
      .out_press (rsp_press_pa),
      .out_dz    (rsp_div_zero)
   );

   assign rsp_temp_centi = o_side.tc;
   assign rsp_fine_temp  = o_side.fine;

endmodule

>>> hdl/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// port-level checks on the compensation block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_temp_centi,
   input logic [31:0] rsp_press_pa,
   input logic        rsp_div_zero
);

   `ASSERT_CLK(a_idle_after_reset, clock, reset, $past(reset) |-> !rsp_valid)
   `ASSERT_CLK(a_dz_zero_press, clock, reset, rsp_valid && rsp_div_zero |-> rsp_press_pa == '0)
   `ASSERT_CLK(a_stall_follows_rsp, clock, reset, req_stall == (rsp_valid && rsp_stall))
   `ASSERT_CLK(a_rsp_held, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_centi))

endmodule

bind temp_pressure_compensation tpc_checker u_tpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_temp_centi (rsp_temp_centi),
   .rsp_press_pa   (rsp_press_pa),
   .rsp_div_zero   (rsp_div_zero)
);

>>> tb/sv/temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_pressure_compensation_tb
// drives raw temperature and pressure pairs through the compensation block
// under several calibration sets, predicts each result in a scoreboard and
// compares every field, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module temp_pressure_compensation_tb
   import tpc_pkg::*;
;

   typedef struct {
      logic [31:0] temp_centi;
      logic [31:0] fine_temp;
      logic [31:0] press_pa;
      logic        div_zero;
   } comp_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class comp_scoreboard_type;
      logic [47:0] cal_temp;
      logic [63:0] cal_press_a;
      logic [63:0] cal_press_b;
      logic [15:0] cal_p9;
      comp_result_type pending[$];

      function void set_cal(input csr_index_type idx, input logic [63:0] v);
         case (idx)
            CSR_CAL_TEMP: cal_temp = v[47:0];
            CSR_CAL_PRESS_A: cal_press_a = v;
            CSR_CAL_PRESS_B: cal_press_b = v;
            CSR_CAL_P9: cal_p9 = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] sra(input logic [31:0] v, input int s);
         return $signed(v) >>> s;
      endfunction

      function logic [31:0] sx(input logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function void note_sample(input logic [19:0] at, input logic [19:0] ap);
         logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] v1, v2, d, sq, fine, tc, p, num;
         logic [63:0] wide;
         comp_result_type r;
         t1 = {16'd0, cal_temp[15:0]};
         t2 = sx(cal_temp[31:16]);
         t3 = sx(cal_temp[47:32]);
         p1 = {16'd0, cal_press_a[15:0]};
         p2 = sx(cal_press_a[31:16]);
         p3 = sx(cal_press_a[47:32]);
         p4 = sx(cal_press_a[63:48]);
         p5 = sx(cal_press_b[15:0]);
         p6 = sx(cal_press_b[31:16]);
         p7 = sx(cal_press_b[47:32]);
         p8 = sx(cal_press_b[63:48]);
         p9 = sx(cal_p9);
         v1 = sra((({12'd0, at} >> 3) - (t1 << 1)) * t2, 11);
         d = ({12'd0, at} >> 4) - t1;
         v2 = sra(sra(d * d, 12) * t3, 14);
         fine = v1 + v2;
         tc = sra(fine * 32'd5 + 32'd128, 8);
         v1 = sra(fine, 1) - 32'd64000;
         sq = sra(v1, 2) * sra(v1, 2);
         v2 = sra(sq, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = sra(v2, 2) + (p4 << 16);
         v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * p1, 15);
         r.div_zero = (v1 == 0);
         if (v1 == 0) begin
            p = 0;
         end else begin
            num = (32'd1048576 - {12'd0, ap} - sra(v2, 12)) * 32'd3125;
            if (num < 32'h8000_0000) p = (num << 1) / v1;
            else p = (num / v1) * 32'd2;
            wide = 64'((p >> 3)) * 64'((p >> 3));
            sq = wide[31:0] >> 13;
            v1 = sra(p9 * sq, 12);
            v2 = sra((p >> 2) * p8, 13);
            p = p + sra(v1 + v2 + p7, 4);
         end
         r.temp_centi = tc;
         r.fine_temp = fine;
         r.press_pa = p;
         pending.push_back(r);
      endfunction

      task check_result(input comp_result_type got);
         comp_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transfer", got.press_pa, 0);
            return;
         end
         want = pending.pop_front();
         if (got.temp_centi !== want.temp_centi)
            report_mismatch("temp_centi", got.temp_centi, want.temp_centi);
         if (got.fine_temp !== want.fine_temp)
            report_mismatch("fine_temp", got.fine_temp, want.fine_temp);
         if (got.press_pa !== want.press_pa)
            report_mismatch("press_pa", got.press_pa, want.press_pa);
         if (got.div_zero !== want.div_zero)
            report_mismatch("div_zero", 32'(got.div_zero), 32'(want.div_zero));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [19:0] req_raw_temp = '0;
   logic [19:0] req_raw_press = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_temp_centi, rsp_fine_temp, rsp_press_pa;
   logic rsp_div_zero;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_cycles = 0;

   comp_scoreboard_type sb = new();

   temp_pressure_compensation u_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // result side: random stall plus long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_temp_centi, rsp_fine_temp, rsp_press_pa, rsp_div_zero});
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_cycles <= 199;
         rsp_stall <= 1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_cal(input csr_index_type idx, input logic [63:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      sb.set_cal(idx, v);
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic send_sample(input logic [19:0] at, input logic [19:0] ap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_raw_temp <= at;
      req_raw_press <= ap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(at, ap);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // typical calibration with random spread around it, or fully random words
   task automatic load_cal(input bit typical);
      logic [63:0] a, b, c;
      if (typical) begin
         a = 64'({16'(-$urandom_range(2000)), 16'($urandom_range(26000, 27000)),
                  16'($urandom_range(27000, 28500))});
         b = 64'({16'(2800 + $urandom_range(600)), 16'(-$urandom_range(10000, 11000)),
                  16'($urandom_range(36000, 38000))});
         c = {16'(-$urandom_range(14000, 15000)), 16'($urandom_range(14000, 16000)),
              16'(-$urandom_range(10)), 16'($urandom_range(200))};
         write_cal(CSR_CAL_TEMP, a);
         write_cal(CSR_CAL_PRESS_A, b);
         write_cal(CSR_CAL_PRESS_B, c);
         write_cal(CSR_CAL_P9, 64'(16'($urandom_range(5000, 7000))));
      end else begin
         write_cal(CSR_CAL_TEMP, {$urandom, $urandom});
         write_cal(CSR_CAL_PRESS_A, {$urandom, $urandom});
         write_cal(CSR_CAL_PRESS_B, {$urandom, $urandom});
         write_cal(CSR_CAL_P9, {$urandom, $urandom});
      end
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) begin
            drain();
            load_cal(($urandom_range(3) != 0));
         end
         if ($urandom_range(3) == 0)
            send_sample(20'($urandom), 20'($urandom));
         else
            send_sample(20'($urandom_range(500000, 560000)),
                        20'($urandom_range(250000, 450000)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // all-zero calibration gives a zero divisor
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      drain();
      write_cal(CSR_CAL_TEMP, 64'(48'hFFFF_FFFF_FFFF));
      write_cal(CSR_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_CAL_P9, 64'h8000);
      send_sample(20'd0, 20'hFFFFF);
      send_sample(20'hFFFFF, 20'd0);
      drain();
      write_cal(CSR_CAL_TEMP, 64'(48'h7FFF_8000_0000));
      write_cal(CSR_CAL_PRESS_A, 64'h8000_7FFF_8000_FFFF);
      write_cal(CSR_CAL_PRESS_B, 64'h7FFF_8000_7FFF_8000);
      write_cal(CSR_CAL_P9, 64'h7FFF);
      send_sample(20'h55555, 20'hAAAAA);
      send_sample(20'hAAAAA, 20'h55555);
      drain();
      // p1 zero forces a zero divisor under typical other words
      write_cal(CSR_CAL_TEMP, 64'({16'd50, 16'd26435, 16'd27504}));
      write_cal(CSR_CAL_PRESS_A, {16'd2855, 16'd24, 16'(-10685), 16'd0});
      write_cal(CSR_CAL_PRESS_B, {16'(-12000), 16'd15500, 16'(-7), 16'd140});
      write_cal(CSR_CAL_P9, 64'd6000);
      send_sample(20'd519888, 20'd415148);
      drain();
      write_cal(CSR_CAL_PRESS_A, {16'd2855, 16'd24, 16'(-10685), 16'd36477});
      for (int i = 0; i < 8; i++)
         send_sample(20'd519888 + 20'(i * 4000), 20'd300000 + 20'(i * 20000));
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      drain();

      send_idle_pct = 11;
      recv_idle_pct = 74;
      random_phase(400);
      send_idle_pct = 74;
      recv_idle_pct = 11;
      random_phase(400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      random_phase(430);
      drain();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
